### design/clsr_pkg.sv
package clsr_pkg;

  // Generator constants.
  localparam logic [30:0] MOD_A      = 31'd2147483563;
  localparam logic [30:0] MOD_B      = 31'd2147483399;
  localparam logic [15:0] MUL_A      = 16'd40014;
  localparam logic [15:0] MUL_B      = 16'd40692;
  // 2^31 is congruent to these values modulo MOD_A and MOD_B.
  localparam logic [7:0]  FOLD_A     = 8'd85;
  localparam logic [7:0]  FOLD_B     = 8'd249;
  localparam logic [30:0] MIX_TOP    = 31'd2147483562;
  localparam logic [30:0] SEED_A_RST = 31'd1;
  localparam logic [30:0] SEED_B_RST = 31'd123456789;
  localparam logic [23:0] FRAC_MAX   = 24'd16777214;

  // Microprogram addressing.
  localparam int unsigned PC_W = 4;
  localparam logic [PC_W-1:0] P_IDLE = 4'd0;
  localparam logic [PC_W-1:0] P_DRAW = 4'd1;
  localparam logic [PC_W-1:0] P_DIV  = 4'd2;
  localparam logic [PC_W-1:0] P_RDT  = 4'd3;
  localparam logic [PC_W-1:0] P_RDA  = 4'd4;
  localparam logic [PC_W-1:0] P_RDB  = 4'd5;
  localparam logic [PC_W-1:0] P_MIX  = 4'd6;
  localparam logic [PC_W-1:0] P_OUT  = 4'd7;
  localparam logic [PC_W-1:0] P_SEED = 4'd8;
  localparam logic [PC_W-1:0] P_WMUL = 4'd9;
  localparam logic [PC_W-1:0] P_WRED = 4'd10;
  localparam logic [PC_W-1:0] P_WWR  = 4'd11;
  localparam logic [PC_W-1:0] P_WEND = 4'd12;

  // Sequencer branch kinds.
  typedef enum logic [2:0] {
    J_NEXT,   // fall through
    J_START,  // wait for an input transfer, branch to target on reseed
    J_LOOP,   // branch to target while the step counter is not zero
    J_WAIT,   // hold while the output register is full, then branch
    J_GOTO    // unconditional branch
  } jmp_e;

  // One control word of the microprogram.
  typedef struct packed {
    logic            seed_ld;
    logic            mul_en;
    logic            mul_b;
    logic            red_a;
    logic            red_b;
    logic            warm_wr;
    logic            mix_from_a;
    logic            div_ld;
    logic            div_step;
    logic            cnt_dec;
    logic            tab_rd;
    logic            mix_upd;
    logic            out_ld;
    jmp_e            jmp;
    logic [PC_W-1:0] tgt;
  } uword_t;

  // Status that steers the sequencer.
  typedef struct packed {
    logic in_valid;
    logic in_func;
    logic cnt_nz;
    logic out_busy;
  } seq_stat_t;

  // Program store.
  function automatic uword_t ucode(logic [PC_W-1:0] pc);
    uword_t w;
    w = '0;
    w.jmp = J_NEXT;
    case (pc)
      P_IDLE: begin
        w.jmp = J_START;
        w.tgt = P_SEED;
      end
      P_DRAW: begin
        w.div_ld = 1'b1;
      end
      P_DIV: begin
        w.div_step = 1'b1;
      end
      P_RDT: begin
        w.tab_rd = 1'b1;
        w.mul_en = 1'b1;
      end
      P_RDA: begin
        w.red_a  = 1'b1;
        w.mul_en = 1'b1;
        w.mul_b  = 1'b1;
      end
      P_RDB: begin
        w.red_b = 1'b1;
      end
      P_MIX: begin
        w.mix_upd = 1'b1;
      end
      P_OUT: begin
        w.out_ld = 1'b1;
        w.jmp    = J_WAIT;
        w.tgt    = P_IDLE;
      end
      P_SEED: begin
        w.seed_ld = 1'b1;
      end
      P_WMUL: begin
        w.mul_en = 1'b1;
      end
      P_WRED: begin
        w.red_a = 1'b1;
      end
      P_WWR: begin
        w.warm_wr = 1'b1;
        w.cnt_dec = 1'b1;
        w.jmp     = J_LOOP;
        w.tgt     = P_WMUL;
      end
      P_WEND: begin
        w.mix_from_a = 1'b1;
        w.jmp        = J_GOTO;
        w.tgt        = P_DRAW;
      end
      default: begin
        w.jmp = J_GOTO;
        w.tgt = P_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

### design/clsr_mulmod.sv
module clsr_mulmod (
  input  logic        clk_i,
  input  logic        mul_en_i,
  input  logic        mul_b_i,
  input  logic [30:0] opnd_i,
  input  logic        red_b_i,
  output logic [30:0] res_o
);

  logic [46:0] prod_q;
  logic [46:0] prod_d;
  logic [15:0] mulc;
  logic [15:0] hi;
  logic [7:0]  fold_k;
  logic [23:0] hi_k;
  logic [31:0] fold;
  logic [31:0] modv;
  logic [31:0] res;

  // Product of the generator value and its multiplier.
  assign mulc   = mul_b_i ? clsr_pkg::MUL_B : clsr_pkg::MUL_A;
  assign prod_d = opnd_i * mulc;

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= prod_d;
    end
  end

  // Fold the bits above 2^31 back in; the sum stays below twice the modulus.
  assign hi     = prod_q[46:31];
  assign fold_k = red_b_i ? clsr_pkg::FOLD_B : clsr_pkg::FOLD_A;
  assign hi_k   = hi * fold_k;
  assign fold   = {1'b0, prod_q[30:0]} + {8'd0, hi_k};
  assign modv   = red_b_i ? {1'b0, clsr_pkg::MOD_B} : {1'b0, clsr_pkg::MOD_A};
  assign res    = (fold >= modv) ? (fold - modv) : fold;
  assign res_o  = res[30:0];

endmodule

### design/clsr_shuf_mem.sv
module clsr_shuf_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned IW    = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  logic [IW-1:0] wr_addr_i,
  input  logic [30:0]   wr_data_i,
  input  logic          rd_en_i,
  input  logic [IW-1:0] rd_addr_i,
  output logic [30:0]   rd_data_o
);

  logic [30:0]      mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [30:0]      rd_q;
  logic             rd_vld_q;

  // Storage with a registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // Entry valid bits; an entry never written reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

### design/clsr_seq.sv
module clsr_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  clsr_pkg::seq_stat_t stat_i,
  output clsr_pkg::uword_t    uw_o,
  output logic                in_ready_o
);

  logic [clsr_pkg::PC_W-1:0] pc_q;
  logic [clsr_pkg::PC_W-1:0] pc_d;
  logic [clsr_pkg::PC_W-1:0] pc_inc;
  clsr_pkg::uword_t          uw;

  assign uw         = clsr_pkg::ucode(pc_q);
  assign uw_o       = uw;
  assign in_ready_o = (uw.jmp == clsr_pkg::J_START);
  assign pc_inc     = pc_q + 1'b1;

  // Next step address.
  always_comb begin
    pc_d = pc_q;
    case (uw.jmp)
      clsr_pkg::J_NEXT: begin
        pc_d = pc_inc;
      end
      clsr_pkg::J_START: begin
        if (stat_i.in_valid) begin
          pc_d = stat_i.in_func ? uw.tgt : pc_inc;
        end
      end
      clsr_pkg::J_LOOP: begin
        pc_d = stat_i.cnt_nz ? uw.tgt : pc_inc;
      end
      clsr_pkg::J_WAIT: begin
        pc_d = stat_i.out_busy ? pc_q : uw.tgt;
      end
      clsr_pkg::J_GOTO: begin
        pc_d = uw.tgt;
      end
      default: begin
        pc_d = clsr_pkg::P_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= clsr_pkg::P_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

### design/combined_lcg_shuffle_rng.sv
// Draw: after the input transfer come the two-step table index estimate, the table read, the
// generator steps on the shared multiplier, the table update and the load of the result.
// Reseed: the seed load and the warm-up steps, which fill the shuffle table, come before the draw.
// One item is in work at a time; a new item is taken while a result waits in the output register.
// Reset (asynchronous, active low) sets the generators to 1 and 123456789, the previous
// combined value to 0 and every shuffle entry to zero.
module combined_lcg_shuffle_rng #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [30:0] seed, [31] zero
  input  logic        s_axis_tuser_i,   // [0] func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o    // [30:0] raw_value, [54:31] unit_fraction, [55] zero
);

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned QW = $clog2(TABLE_DEPTH) + 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 8);
  localparam int unsigned SEL_DIV = 1 + clsr_pkg::MIX_TOP / TABLE_DEPTH;
  // floor(2^31 / SEL_DIV); the product estimate is then exact or one short.
  localparam logic [QW-1:0] SEL_RCP   = QW'((64'd1 << 31) / SEL_DIV);
  localparam logic [30:0]   SEL_DIV_W = 31'(SEL_DIV);
  localparam logic [CW-1:0] WARM_CNT  = CW'(TABLE_DEPTH + 7);

  clsr_pkg::uword_t    uw;
  clsr_pkg::seq_stat_t stat;
  logic                in_acc;
  logic                out_busy;
  logic                out_ld;

  logic [30:0]   a_q, b_q, mix_q, seed_q;
  logic [30:0]   a_d, b_d, mix_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [QW-1:0] quo_q, quo_d;
  logic [IW-1:0] idx_q, idx_sel;
  logic          out_vld_q;
  logic [30:0]   out_raw_q;
  logic [23:0]   out_frac_q;

  logic [30:0]      red;
  logic [30:0]      entry;
  logic [31:0]      raw;
  logic [30+QW:0]   est_prod;
  logic [QW-1:0]    quo_est;
  logic [QW-1:0]    quo_inc;
  logic [30+QW:0]   chk_prod;
  logic             quo_fix;
  logic             tab_wr;
  logic [IW-1:0]    tab_waddr;
  logic [23:0]      q0;
  logic [24:0]      q1, q;
  logic [31:0]      q1_k;
  logic [55:0]      lhs, rhs;
  logic [23:0]      frac;

  // Control sequencer.
  assign stat.in_valid = s_axis_tvalid_i;
  assign stat.in_func  = s_axis_tuser_i;
  assign stat.cnt_nz   = (cnt_q != '0);
  assign stat.out_busy = out_busy;

  clsr_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .uw_o       (uw),
    .in_ready_o (s_axis_tready_o)
  );

  assign in_acc   = s_axis_tvalid_i & s_axis_tready_o;
  assign out_busy = out_vld_q & ~m_axis_tready_i;
  assign out_ld   = uw.out_ld & ~out_busy;

  // Shared modular multiplier.
  clsr_mulmod u_mulmod (
    .clk_i    (clk_i),
    .mul_en_i (uw.mul_en),
    .mul_b_i  (uw.mul_b),
    .opnd_i   (uw.mul_b ? b_q : a_q),
    .red_b_i  (uw.red_b),
    .res_o    (red)
  );

  // Shuffle table: warm-up fill or replacement of the selected entry.
  assign tab_wr    = (uw.warm_wr & (cnt_q < CW'(TABLE_DEPTH))) | uw.mix_upd;
  assign tab_waddr = uw.mix_upd ? idx_q : cnt_q[IW-1:0];

  clsr_shuf_mem #(
    .DEPTH (TABLE_DEPTH),
    .IW    (IW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (tab_wr),
    .wr_addr_i (tab_waddr),
    .wr_data_i (a_q),
    .rd_en_i   (uw.tab_rd),
    .rd_addr_i (idx_sel),
    .rd_data_o (entry)
  );

  // Table index: a reciprocal estimate in one step, then a single upward correction.
  assign est_prod = mix_q * SEL_RCP;
  assign quo_est  = est_prod[30+QW:31];
  assign quo_inc  = quo_q + 1'b1;
  assign chk_prod = quo_inc * SEL_DIV_W;
  assign quo_fix  = (chk_prod <= {{QW{1'b0}}, mix_q});
  assign quo_d    = uw.div_ld ? quo_est : (quo_fix ? quo_inc : quo_q);

  // Clamp the selector to the last entry.
  assign idx_sel = (quo_q >= QW'(TABLE_DEPTH)) ? IW'(TABLE_DEPTH - 1) : quo_q[IW-1:0];

  // Step counter for the warm-up.
  always_comb begin
    cnt_d = cnt_q;
    if (uw.seed_ld) begin
      cnt_d = WARM_CNT;
    end else if (uw.cnt_dec) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Combine the selected entry with the second generator, wrapping into range.
  assign raw = (entry > b_q) ? ({1'b0, entry} - {1'b0, b_q})
                             : ({1'b0, entry} + {1'b0, clsr_pkg::MIX_TOP} - {1'b0, b_q});

  // Generator and combined value updates.
  always_comb begin
    a_d   = a_q;
    b_d   = b_q;
    mix_d = mix_q;
    if (uw.seed_ld) begin
      a_d = seed_q;
      b_d = seed_q;
    end
    if (uw.red_a) begin
      a_d = red;
    end
    if (uw.red_b) begin
      b_d = red;
    end
    if (uw.mix_from_a) begin
      mix_d = a_q;
    end
    if (uw.mix_upd) begin
      mix_d = raw[30:0];
    end
  end

  // Q0.24 fraction: the quotient is y>>7 or one more; a single compare decides.
  assign q0   = mix_q[30:7];
  assign q1   = {1'b0, q0} + 25'd1;
  assign q1_k = q1 * 7'd85;
  assign lhs  = {1'b0, mix_q, 24'd0} + {24'd0, q1_k};
  assign rhs  = {q1, 31'd0};
  assign q    = (lhs >= rhs) ? q1 : {1'b0, q0};
  assign frac = (q >= {1'b0, clsr_pkg::FRAC_MAX}) ? clsr_pkg::FRAC_MAX : q[23:0];

  // State with defined reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q       <= clsr_pkg::SEED_A_RST;
      b_q       <= clsr_pkg::SEED_B_RST;
      mix_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      a_q   <= a_d;
      b_q   <= b_d;
      mix_q <= mix_d;
      if (out_ld) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Working registers without reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      seed_q <= (s_axis_tdata_i[30:0] == '0) ? 31'd1 : s_axis_tdata_i[30:0];
    end
    cnt_q <= cnt_d;
    if (uw.div_ld || uw.div_step) begin
      quo_q <= quo_d;
    end
    if (uw.tab_rd) begin
      idx_q <= idx_sel;
    end
    if (out_ld) begin
      out_raw_q  <= mix_q;
      out_frac_q <= frac;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, out_frac_q, out_raw_q};

endmodule
